>>> rtl/itda_pkg.sv
package itda_pkg;

    localparam int VALUE_WIDTH = 32;
    localparam int NUM_DIGITS  = (VALUE_WIDTH * 3) / 10 + 1;
    localparam int BCD_WIDTH   = NUM_DIGITS * 4;
    localparam int BIT_CNT_W   = $clog2(VALUE_WIDTH);
    localparam int DIG_CNT_W   = $clog2(NUM_DIGITS + 1);

    localparam logic [7:0] CHAR_ZERO  = 8'd48;
    localparam logic [7:0] CHAR_MINUS = 8'd45;

endpackage

>>> rtl/itda_dabble_step.sv
module itda_dabble_step (
    input  logic [itda_pkg::BCD_WIDTH-1:0] i_bcd,
    input  logic                           i_bit,
    output logic [itda_pkg::BCD_WIDTH-1:0] o_bcd
);

    logic [itda_pkg::BCD_WIDTH-1:0] w_adj;

    genvar g;
    generate
        for (g = 0; g < itda_pkg::NUM_DIGITS; g++) begin : g_digit
            assign w_adj[g*4 +: 4] = (i_bcd[g*4 +: 4] >= 4'd5) ? i_bcd[g*4 +: 4] + 4'd3
                                                                : i_bcd[g*4 +: 4];
        end
    endgenerate

    assign o_bcd = {w_adj[itda_pkg::BCD_WIDTH-2:0], i_bit};

endmodule

>>> rtl/int_to_decimal_ascii.sv
// Signed integer to decimal ASCII text. Each request on the input carries one
// two's complement integer of itda_pkg::VALUE_WIDTH bits (32); the block sends
// its text one character per output request, most significant first: a '-'
// for a negative value, then the digits without leading zeros, zero giving a
// single '0'. o_last_char marks the final character; no null terminator is
// sent. The most negative value converts correctly. The magnitude is turned
// into BCD by a shift-and-add-3 unit that takes one bit per cycle,
// leading zero digits are dropped one per cycle, and then one character
// leaves per cycle while the output is not stalled. After a request is
// taken o_ready stays low while the value is converted, its leading zeros
// are dropped and its characters are sent, stalls of the output included,
// until the last character has been registered for the output.
module int_to_decimal_ascii (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_valid,
    output logic                                  o_ready,
    input  logic signed [itda_pkg::VALUE_WIDTH-1:0] i_value,
    output logic                                  o_valid,
    input  logic                                  i_ready,
    output logic [7:0]                            o_char_code,
    output logic                                  o_last_char
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_CONV,
        S_SKIP,
        S_SIGN,
        S_EMIT
    } t_state;

    t_state                           r_state,   n_state;
    logic [itda_pkg::VALUE_WIDTH-1:0] r_bits,    n_bits;
    logic [itda_pkg::BCD_WIDTH-1:0]   r_bcd,     n_bcd;
    logic [itda_pkg::BIT_CNT_W-1:0]   r_bit_cnt, n_bit_cnt;
    logic [itda_pkg::DIG_CNT_W-1:0]   r_dig_cnt, n_dig_cnt;
    logic                             r_neg,     n_neg;
    logic                             r_out_valid, n_out_valid;
    logic [7:0]                       r_char,    n_char;
    logic                             r_last,    n_last;

    logic [itda_pkg::BCD_WIDTH-1:0]   w_step_bcd;
    logic [3:0]                       w_top;
    logic                             w_slot;
    logic [itda_pkg::VALUE_WIDTH-1:0] w_raw;

    itda_dabble_step u_step (
        .i_bcd (r_bcd),
        .i_bit (r_bits[itda_pkg::VALUE_WIDTH-1]),
        .o_bcd (w_step_bcd)
    );

    assign w_top  = r_bcd[itda_pkg::BCD_WIDTH-1 -: 4];
    assign w_slot = !r_out_valid || i_ready;
    assign w_raw  = i_value;

    assign o_ready     = (r_state == S_IDLE);
    assign o_valid     = r_out_valid;
    assign o_char_code = r_char;
    assign o_last_char = r_last;

    always_comb begin
        n_state     = r_state;
        n_bits      = r_bits;
        n_bcd       = r_bcd;
        n_bit_cnt   = r_bit_cnt;
        n_dig_cnt   = r_dig_cnt;
        n_neg       = r_neg;
        n_out_valid = r_out_valid && !i_ready;
        n_char      = r_char;
        n_last      = r_last;

        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_neg     = w_raw[itda_pkg::VALUE_WIDTH-1];
                    n_bits    = w_raw[itda_pkg::VALUE_WIDTH-1] ? (~w_raw + 1'b1) : w_raw;
                    n_bcd     = '0;
                    n_bit_cnt = '0;
                    n_state   = S_CONV;
                end
            end
            S_CONV: begin
                n_bcd     = w_step_bcd;
                n_bits    = {r_bits[itda_pkg::VALUE_WIDTH-2:0], 1'b0};
                n_bit_cnt = r_bit_cnt + 1'b1;
                if (r_bit_cnt == itda_pkg::BIT_CNT_W'(itda_pkg::VALUE_WIDTH - 1)) begin
                    n_dig_cnt = itda_pkg::DIG_CNT_W'(itda_pkg::NUM_DIGITS);
                    n_state   = S_SKIP;
                end
            end
            S_SKIP: begin
                if (w_top == 4'd0 && r_dig_cnt > itda_pkg::DIG_CNT_W'(1)) begin
                    n_bcd     = {r_bcd[itda_pkg::BCD_WIDTH-5:0], 4'd0};
                    n_dig_cnt = r_dig_cnt - 1'b1;
                end else if (r_neg) begin
                    n_state = S_SIGN;
                end else begin
                    n_state = S_EMIT;
                end
            end
            S_SIGN: begin
                if (w_slot) begin
                    n_out_valid = 1'b1;
                    n_char      = itda_pkg::CHAR_MINUS;
                    n_last      = 1'b0;
                    n_state     = S_EMIT;
                end
            end
            S_EMIT: begin
                if (w_slot) begin
                    n_out_valid = 1'b1;
                    n_char      = itda_pkg::CHAR_ZERO + {4'd0, w_top};
                    n_last      = (r_dig_cnt == itda_pkg::DIG_CNT_W'(1));
                    n_bcd       = {r_bcd[itda_pkg::BCD_WIDTH-5:0], 4'd0};
                    n_dig_cnt   = r_dig_cnt - 1'b1;
                    if (r_dig_cnt == itda_pkg::DIG_CNT_W'(1)) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
        r_bits    <= n_bits;
        r_bcd     <= n_bcd;
        r_bit_cnt <= n_bit_cnt;
        r_dig_cnt <= n_dig_cnt;
        r_neg     <= n_neg;
        r_char    <= n_char;
        r_last    <= n_last;
    end

endmodule
